@@ hdl/mlid_pkg.sv @@
`timescale 1ns / 1ps
package mlid_pkg;

  // instruction format marks and masks
  localparam logic [15:0] LONG_MARK     = 16'h8000;
  localparam logic [31:0] LOW_HALF_MASK = 32'h0000_7FFF;
  localparam logic [31:0] WORD30_MASK   = 32'h3FFF_FFFF;
  localparam logic [31:0] JUMP32_REGION = 32'hFC00_0000;
  localparam logic [31:0] JUMP16_REGION = 32'hFFFF_F000;

  // mnemonic codes
  localparam logic [6:0] MN_INVALID = 7'd0,  MN_NOP    = 7'd1,  MN_SYSCALL = 7'd2;
  localparam logic [6:0] MN_TRAP    = 7'd3,  MN_SDBBP  = 7'd4,  MN_BR      = 7'd5;
  localparam logic [6:0] MN_PFLUSH  = 7'd6,  MN_ALW    = 7'd7,  MN_ASW     = 7'd8;
  localparam logic [6:0] MN_ADD     = 7'd9,  MN_ADDC   = 7'd10, MN_SUB     = 7'd11;
  localparam logic [6:0] MN_CMP     = 7'd12, MN_CMPZ   = 7'd13, MN_NEG     = 7'd14;
  localparam logic [6:0] MN_AND     = 7'd15, MN_OR     = 7'd16, MN_NOT     = 7'd17;
  localparam logic [6:0] MN_XOR     = 7'd18, MN_BITCLR = 7'd19, MN_BITSET  = 7'd20;
  localparam logic [6:0] MN_BITTST  = 7'd21, MN_BITTGL = 7'd22, MN_SLL     = 7'd23;
  localparam logic [6:0] MN_SRL     = 7'd24, MN_SRA    = 7'd25, MN_ROR     = 7'd26;
  localparam logic [6:0] MN_RORC    = 7'd27, MN_ROL    = 7'd28, MN_ROLC    = 7'd29;
  localparam logic [6:0] MN_MUL     = 7'd30, MN_MULU   = 7'd31, MN_DIV     = 7'd32;
  localparam logic [6:0] MN_DIVU    = 7'd33, MN_MFCEL  = 7'd34, MN_MTCEL   = 7'd37;
  localparam logic [6:0] MN_MFSR    = 7'd40, MN_MTSR   = 7'd41, MN_T       = 7'd42;
  localparam logic [6:0] MN_MV      = 7'd43, MN_EXTSB  = 7'd44, MN_LCB     = 7'd48;
  localparam logic [6:0] MN_LCW     = 7'd49, MN_LCE    = 7'd50, MN_SCB     = 7'd51;
  localparam logic [6:0] MN_SCW     = 7'd52, MN_SCE    = 7'd53, MN_SLLI    = 7'd54;
  localparam logic [6:0] MN_SRLI    = 7'd55, MN_ADDI   = 7'd61, MN_J       = 7'd66;
  localparam logic [6:0] MN_LW      = 7'd67, MN_LH     = 7'd68, MN_LHU     = 7'd69;
  localparam logic [6:0] MN_LB      = 7'd70, MN_SW     = 7'd71, MN_SH      = 7'd72;
  localparam logic [6:0] MN_LBU     = 7'd73, MN_SB     = 7'd74, MN_B       = 7'd75;
  localparam logic [6:0] MN_ADDIS   = 7'd76, MN_ADDRI  = 7'd81, MN_ANDRI   = 7'd82;
  localparam logic [6:0] MN_ORRI    = 7'd83, MN_MLFH   = 7'd84, MN_MHFL    = 7'd85;
  localparam logic [6:0] MN_POP     = 7'd86, MN_PUSH   = 7'd87, MN_LDIU    = 7'd88;
  localparam logic [6:0] MN_ADDEI   = 7'd89, MN_LWP    = 7'd90, MN_LHP     = 7'd91;
  localparam logic [6:0] MN_LBUP    = 7'd92, MN_SWP    = 7'd93, MN_SHP     = 7'd94;
  localparam logic [6:0] MN_SBP     = 7'd95;

  // operand layouts
  localparam logic [4:0] F_NONE = 5'd0,  F_R    = 5'd1,  F_RR   = 5'd2,  F_RSR = 5'd3;
  localparam logic [4:0] F_RRR  = 5'd4,  F_D    = 5'd5,  F_RD   = 5'd6,  F_RRD = 5'd7;
  localparam logic [4:0] F_W    = 5'd8,  F_RH   = 5'd9,  F_RRH  = 5'd10, F_RM  = 5'd11;
  localparam logic [4:0] F_RMD  = 5'd12, F_RMDP = 5'd13, F_RMPD = 5'd14, F_MP  = 5'd15;
  localparam logic [4:0] F_RMP  = 5'd16;

  // suffixes
  localparam logic [2:0] S_NONE = 3'd0, S_C = 3'd1, S_L = 3'd2, S_F = 3'd3;
  localparam logic [2:0] S_BANG = 3'd4, S_LBANG = 3'd5;

  localparam logic [3:0] COND_ALWAYS = 4'd15;
  localparam logic [1:0] TC_NONE     = 2'd3;

  localparam logic [2:0] LEN_NONE  = 3'd0;
  localparam logic [2:0] LEN_SHORT = 3'd2;
  localparam logic [2:0] LEN_LONG  = 3'd4;

  // decoded instruction
  typedef struct packed {
    logic [2:0]  consumed_bytes;
    logic [6:0]  mnemonic;
    logic [3:0]  condition;
    logic [1:0]  test_condition;
    logic [2:0]  suffix;
    logic [4:0]  operand_form;
    logic [4:0]  reg_first;
    logic [4:0]  reg_second;
    logic [4:0]  reg_third;
    logic [31:0] immediate;
  } dec_t;

  // load/store mnemonic by 3-bit subop
  function automatic logic [6:0] mem_op(input logic [2:0] sel);
    logic [6:0] r;
    case (sel)
      3'd0:    r = MN_LW;
      3'd1:    r = MN_LH;
      3'd2:    r = MN_LHU;
      3'd3:    r = MN_LB;
      3'd4:    r = MN_SW;
      3'd5:    r = MN_SH;
      3'd6:    r = MN_LBU;
      default: r = MN_SB;
    endcase
    return r;
  endfunction

  // 16-bit alu/memory group mnemonic
  function automatic logic [6:0] alu16_op(input logic [3:0] sel);
    logic [6:0] r;
    case (sel)
      4'h0:    r = MN_ADD;
      4'h1:    r = MN_SUB;
      4'h2:    r = MN_NEG;
      4'h3:    r = MN_CMP;
      4'h4:    r = MN_AND;
      4'h5:    r = MN_OR;
      4'h6:    r = MN_NOT;
      4'h7:    r = MN_XOR;
      4'h8:    r = MN_LW;
      4'h9:    r = MN_LH;
      4'hA:    r = MN_POP;
      4'hB:    r = MN_LBU;
      4'hC:    r = MN_SW;
      4'hD:    r = MN_SH;
      4'hE:    r = MN_PUSH;
      default: r = MN_SB;
    endcase
    return r;
  endfunction

  // fill mnemonic, layout, registers and immediate
  function automatic dec_t put(input dec_t d, input logic [6:0] mn, input logic [4:0] f,
                               input logic [4:0] r1, input logic [4:0] r2,
                               input logic [4:0] r3, input logic [31:0] imm);
    dec_t o;
    o = d;
    o.mnemonic     = mn;
    o.operand_form = f;
    o.reg_first    = r1;
    o.reg_second   = r2;
    o.reg_third    = r3;
    o.immediate    = imm;
    return o;
  endfunction

endpackage

@@ hdl/mlid_req_if.sv @@
`timescale 1ns / 1ps
interface mlid_req_if;
  logic        valid;
  logic        ready;
  logic [15:0] first_half;
  logic [15:0] second_half;
  logic [2:0]  bytes_available;
  logic [31:0] pc;

  modport source (output valid, first_half, second_half, bytes_available, pc, input ready);
  modport sink (input valid, first_half, second_half, bytes_available, pc, output ready);
endinterface

@@ hdl/mlid_rsp_if.sv @@
`timescale 1ns / 1ps
interface mlid_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  consumed_bytes;
  logic [6:0]  mnemonic;
  logic [3:0]  condition;
  logic [1:0]  test_condition;
  logic [2:0]  suffix;
  logic [4:0]  operand_form;
  logic [4:0]  reg_first;
  logic [4:0]  reg_second;
  logic [4:0]  reg_third;
  logic [31:0] immediate;

  modport source (output valid, consumed_bytes, mnemonic, condition, test_condition, suffix,
                  operand_form, reg_first, reg_second, reg_third, immediate, input ready);
  modport sink (input valid, consumed_bytes, mnemonic, condition, test_condition, suffix,
                operand_form, reg_first, reg_second, reg_third, immediate, output ready);
endinterface

@@ hdl/mlid_decode.sv @@
`timescale 1ns / 1ps
module mlid_decode import mlid_pkg::*; (
  input  logic [15:0] first_half,
  input  logic [15:0] second_half,
  input  logic [2:0]  bytes_available,
  input  logic [31:0] pc,
  output dec_t        dec
);

  logic [31:0] w;
  logic [4:0]  major, rd, ra, rb;
  logic [5:0]  op;
  logic [2:0]  c_suf, l_suf;
  logic [6:0]  grp;
  logic [31:0] br32_disp;
  logic [3:0]  h_rd, h_ra, h_lo;
  logic [4:0]  imm5;
  logic [2:0]  sub;
  logic [31:0] br16_disp;
  logic        is_long, enough;
  dec_t        d32, d16;

  // field extraction
  assign w     = ((32'(first_half) & LOW_HALF_MASK) | (32'(second_half) << 15)) & WORD30_MASK;
  assign major = w[29:25];
  assign rd    = w[24:20];
  assign ra    = w[19:15];
  assign rb    = w[14:10];
  assign op    = w[6:1];
  assign c_suf = w[0] ? S_C : S_NONE;
  assign l_suf = w[0] ? S_L : S_NONE;
  assign grp   = (major == 5'h01) ? MN_ADDI : MN_ADDIS;
  assign br32_disp = {{12{w[24]}}, w[24:15], w[9:1], 1'b0};

  assign h_rd = first_half[11:8];
  assign h_ra = first_half[7:4];
  assign h_lo = first_half[3:0];
  assign imm5 = first_half[7:3];
  assign sub  = first_half[2:0];
  assign br16_disp = {{23{first_half[7]}}, first_half[7:0], 1'b0};

  // 32-bit formats
  always_comb begin
    d32 = '0;
    d32.condition = COND_ALWAYS;
    d32.test_condition = TC_NONE;
    case (major)
      5'h00: begin
        case (op)
          6'h00: d32 = put(d32, MN_NOP, F_NONE, '0, '0, '0, '0);
          6'h01: d32 = put(d32, MN_SYSCALL, F_D, '0, '0, '0, 32'(w[24:10]));
          6'h02: begin
            d32 = put(d32, MN_TRAP, F_D, '0, '0, '0, 32'(ra));
            d32.condition = rb[3:0];
          end
          6'h03: d32 = put(d32, MN_SDBBP, F_D, '0, '0, '0, 32'(ra));
          6'h04: begin
            d32 = put(d32, MN_BR, F_R, ra, '0, '0, '0);
            d32.condition = rb[3:0];
            d32.suffix = l_suf;
          end
          6'h05: d32 = put(d32, MN_PFLUSH, F_NONE, '0, '0, '0, '0);
          6'h06: d32 = put(d32, MN_ALW, F_RM, rd, ra, '0, '0);
          6'h07: d32 = put(d32, MN_ASW, F_RM, rd, ra, '0, '0);
          6'h0C, 6'h0D: begin
            d32 = put(d32, op[0] ? MN_CMPZ : MN_CMP, F_RR, ra, rb, '0, '0);
            d32.test_condition = rd[1:0];
            d32.suffix = c_suf;
          end
          6'h0F: begin
            d32 = put(d32, MN_NEG, F_RR, rd, ra, '0, '0);
            d32.suffix = c_suf;
          end
          6'h14, 6'h15, 6'h17: begin
            d32 = put(d32, (op == 6'h14) ? MN_BITCLR : ((op == 6'h15) ? MN_BITSET : MN_BITTGL),
                      F_RRD, rd, ra, '0, 32'(rb));
            d32.suffix = c_suf;
          end
          6'h16: begin
            d32 = put(d32, MN_BITTST, F_RD, ra, '0, '0, 32'(rb));
            d32.suffix = c_suf;
          end
          6'h20: begin
            d32 = put(d32, MN_MUL, F_RR, ra, rb, '0, '0);
            d32.suffix = w[0] ? S_F : S_NONE;
          end
          6'h21: d32 = put(d32, MN_MULU, F_RR, ra, rb, '0, '0);
          6'h22: d32 = put(d32, MN_DIV, F_RR, ra, rb, '0, '0);
          6'h23: d32 = put(d32, MN_DIVU, F_RR, ra, rb, '0, '0);
          6'h24, 6'h25: begin
            if (rb == 5'd1 || rb == 5'd2) begin
              d32 = put(d32, (op[0] ? MN_MTCEL : MN_MFCEL) + 7'(rb) - 7'd1, F_R, rd, '0, '0,
                        '0);
            end else if (rb == 5'd3) begin
              d32 = put(d32, (op[0] ? MN_MTCEL : MN_MFCEL) + 7'd2, F_RR, rd, ra, '0, '0);
            end
          end
          6'h28: d32 = put(d32, MN_MFSR, F_RSR, ra, rb, '0, '0);
          6'h29: d32 = put(d32, MN_MTSR, F_RSR, ra, rb, '0, '0);
          6'h2A: begin
            d32 = put(d32, MN_T, F_NONE, '0, '0, '0, '0);
            d32.condition = rb[3:0];
          end
          6'h2B: begin
            d32 = put(d32, MN_MV, F_RR, rd, ra, '0, '0);
            d32.condition = rb[3:0];
          end
          6'h2C, 6'h2D, 6'h2E, 6'h2F: begin
            d32 = put(d32, MN_EXTSB + 7'(op[1:0]), F_RR, rd, ra, '0, '0);
            d32.suffix = c_suf;
          end
          6'h30: d32 = put(d32, MN_LCB, F_MP, '0, ra, '0, '0);
          6'h31: d32 = put(d32, MN_LCW, F_RMP, rd, ra, '0, '0);
          6'h33: d32 = put(d32, MN_LCE, F_RMP, rd, ra, '0, '0);
          6'h34: d32 = put(d32, MN_SCB, F_RMP, rd, ra, '0, '0);
          6'h35: d32 = put(d32, MN_SCW, F_RMP, rd, ra, '0, '0);
          6'h37: d32 = put(d32, MN_SCE, F_MP, '0, ra, '0, '0);
          6'h38: begin
            d32 = put(d32, MN_SLLI, F_RRD, rd, ra, '0, 32'(rb));
            d32.suffix = c_suf;
          end
          6'h3A, 6'h3B, 6'h3C, 6'h3D, 6'h3E, 6'h3F: begin
            d32 = put(d32, MN_SRLI + 7'(op - 6'h3A), F_RRD, rd, ra, '0, 32'(rb));
            d32.suffix = c_suf;
          end
          // three-register alu group
          6'h08, 6'h09, 6'h0A, 6'h10, 6'h11, 6'h12, 6'h13, 6'h18,
          6'h1A, 6'h1B, 6'h1C, 6'h1D, 6'h1E, 6'h1F: begin
            case (op)
              6'h08:   d32.mnemonic = MN_ADD;
              6'h09:   d32.mnemonic = MN_ADDC;
              6'h0A:   d32.mnemonic = MN_SUB;
              6'h10:   d32.mnemonic = MN_AND;
              6'h11:   d32.mnemonic = MN_OR;
              6'h12:   d32.mnemonic = MN_NOT;
              6'h13:   d32.mnemonic = MN_XOR;
              6'h18:   d32.mnemonic = MN_SLL;
              6'h1A:   d32.mnemonic = MN_SRL;
              6'h1B:   d32.mnemonic = MN_SRA;
              6'h1C:   d32.mnemonic = MN_ROR;
              6'h1D:   d32.mnemonic = MN_RORC;
              6'h1E:   d32.mnemonic = MN_ROL;
              default: d32.mnemonic = MN_ROLC;
            endcase
            d32 = put(d32, d32.mnemonic, F_RRR, rd, ra, rb, '0);
            d32.suffix = c_suf;
          end
          default: ;
        endcase
      end
      // 16-bit immediate group
      5'h01, 5'h05: begin
        case (w[19:17])
          3'd0: begin
            d32 = put(d32, grp, F_RD, rd, '0, '0, {{16{w[16]}}, w[16:1]});
            d32.suffix = c_suf;
          end
          3'd2: begin
            d32 = put(d32, grp + 7'd1, F_RD, rd, '0, '0, {{16{w[16]}}, w[16:1]});
            d32.suffix = c_suf;
          end
          3'd4: begin
            d32 = put(d32, grp + 7'd2, F_RH, rd, '0, '0, 32'(w[16:1]));
            d32.suffix = c_suf;
          end
          3'd5: begin
            d32 = put(d32, grp + 7'd3, F_RH, rd, '0, '0, 32'(w[16:1]));
            d32.suffix = c_suf;
          end
          3'd6: begin
            d32 = put(d32, grp + 7'd4, (grp == MN_ADDI) ? F_RD : F_RH, rd, '0, '0,
                      32'(w[16:1]));
            d32.suffix = c_suf;
          end
          default: ;
        endcase
      end
      5'h02: begin
        d32 = put(d32, MN_J, F_W, '0, '0, '0, (pc & JUMP32_REGION) | 32'({w[24:1], 1'b0}));
        d32.suffix = l_suf;
      end
      5'h03, 5'h07: begin
        d32 = put(d32, mem_op(w[2:0]), (major == 5'h03) ? F_RMDP : F_RMPD, rd, ra, '0,
                  {{20{w[14]}}, w[14:3]});
      end
      5'h04: begin
        d32 = put(d32, MN_B, F_W, '0, '0, '0, pc + br32_disp);
        d32.condition = w[13:10];
        d32.suffix = l_suf;
      end
      5'h08, 5'h0C, 5'h0D: begin
        d32 = put(d32, (major == 5'h08) ? MN_ADDRI : ((major == 5'h0C) ? MN_ANDRI : MN_ORRI),
                  F_RRH, ra, rd, '0, {{18{w[14]}}, w[14:1]});
        d32.suffix = c_suf;
      end
      5'h10, 5'h11, 5'h12, 5'h13, 5'h14, 5'h15, 5'h16, 5'h17: begin
        d32 = put(d32, mem_op(major[2:0]), F_RMD, rd, ra, '0, {{17{w[14]}}, w[14:0]});
      end
      default: ;
    endcase
  end

  // 16-bit formats
  always_comb begin
    d16 = '0;
    d16.condition = COND_ALWAYS;
    d16.test_condition = TC_NONE;
    case (first_half[14:12])
      3'd0: begin
        case (h_lo)
          4'h0: d16 = put(d16, MN_NOP, F_NONE, '0, '0, '0, '0);
          4'h1: d16 = put(d16, MN_MLFH, F_RR, 5'(h_rd), {1'b1, h_ra}, '0, '0);
          4'h2: d16 = put(d16, MN_MHFL, F_RR, {1'b1, h_rd}, 5'(h_ra), '0, '0);
          4'h3: d16 = put(d16, MN_MV, F_RR, 5'(h_rd), 5'(h_ra), '0, '0);
          4'h4, 4'hC: d16 = put(d16, MN_BR, F_R, 5'(h_ra), '0, '0, '0);
          4'h5: d16 = put(d16, MN_T, F_R, 5'(h_ra), '0, '0, '0);
          default: ;
        endcase
        if (h_lo == 4'h4 || h_lo == 4'hC || h_lo == 4'h5) begin
          d16.condition = h_rd;
        end
        if (h_lo == 4'hC) begin
          d16.suffix = S_LBANG;
        end else if (h_lo <= 4'h5) begin
          d16.suffix = S_BANG;
        end
      end
      3'd1: begin
        if (h_lo <= 4'h1 && h_rd <= 4'h1) begin
          d16 = put(d16, ((h_lo == 4'h0) ? MN_MTCEL : MN_MFCEL) + 7'(h_rd), F_R, 5'(h_ra),
                    '0, '0, '0);
          d16.suffix = S_BANG;
        end
      end
      3'd2: begin
        if (!h_lo[3]) begin
          d16 = put(d16, alu16_op(h_lo), F_RR, 5'(h_rd), 5'(h_ra), '0, '0);
        end else if (h_lo == 4'hA || h_lo == 4'hE) begin
          d16 = put(d16, alu16_op(h_lo), F_RM, {first_half[7], h_rd}, 5'(first_half[6:4]),
                    '0, '0);
        end else begin
          d16 = put(d16, alu16_op(h_lo), F_RM, 5'(h_rd), 5'(h_ra), '0, '0);
        end
        d16.suffix = S_BANG;
      end
      3'd3: begin
        d16 = put(d16, MN_J, F_W, '0, '0, '0,
                  (pc & JUMP16_REGION) | 32'({first_half[11:1], 1'b0}));
        d16.suffix = first_half[0] ? S_LBANG : S_BANG;
      end
      3'd4: begin
        d16 = put(d16, MN_B, F_W, '0, '0, '0, pc + br16_disp);
        d16.condition = h_rd;
        d16.suffix = S_BANG;
      end
      3'd5: begin
        d16 = put(d16, MN_LDIU, F_RD, 5'(h_rd), '0, '0, 32'(first_half[7:0]));
        d16.suffix = S_BANG;
      end
      3'd6: begin
        case (sub)
          3'd0: d16 = put(d16, MN_ADDEI, F_RD, 5'(h_rd), '0, '0, {{27{imm5[4]}}, imm5});
          3'd1: d16 = put(d16, MN_SLLI, F_RD, 5'(h_rd), '0, '0, 32'(imm5));
          3'd2: d16 = put(d16, MN_SDBBP, F_D, '0, '0, '0, 32'(imm5));
          3'd3: d16 = put(d16, MN_SRLI, F_RD, 5'(h_rd), '0, '0, 32'(imm5));
          3'd4: d16 = put(d16, MN_BITCLR, F_RD, 5'(h_rd), '0, '0, 32'(imm5));
          3'd5: d16 = put(d16, MN_BITSET, F_RD, 5'(h_rd), '0, '0, 32'(imm5));
          3'd6: d16 = put(d16, MN_BITTST, F_RD, 5'(h_rd), '0, '0, 32'(imm5));
          default: ;
        endcase
        if (sub != 3'd7) begin
          d16.suffix = S_BANG;
        end
      end
      default: begin
        case (sub)
          3'd0: d16 = put(d16, MN_LWP, F_RD, 5'(h_rd), '0, '0, 32'({imm5, 2'b00}));
          3'd1: d16 = put(d16, MN_LHP, F_RD, 5'(h_rd), '0, '0, 32'({imm5, 1'b0}));
          3'd3: d16 = put(d16, MN_LBUP, F_RD, 5'(h_rd), '0, '0, 32'(imm5));
          3'd4: d16 = put(d16, MN_SWP, F_RD, 5'(h_rd), '0, '0, 32'({imm5, 2'b00}));
          3'd5: d16 = put(d16, MN_SHP, F_RD, 5'(h_rd), '0, '0, 32'({imm5, 1'b0}));
          3'd6: d16 = put(d16, MN_SBP, F_RD, 5'(h_rd), '0, '0, 32'(imm5));
          default: ;
        endcase
        if (sub != 3'd2 && sub != 3'd7) begin
          d16.suffix = S_BANG;
        end
      end
    endcase
  end

  // length check and final select; counts above four saturate
  assign is_long = (first_half & LONG_MARK) != 16'h0000;
  assign enough  = is_long ? (bytes_available >= 3'd4) : (bytes_available >= 3'd2);

  always_comb begin
    dec = '0;
    if (enough) begin
      if (is_long) begin
        dec = d32;
        dec.consumed_bytes = LEN_LONG;
      end else begin
        dec = d16;
        dec.consumed_bytes = LEN_SHORT;
      end
    end else begin
      dec.consumed_bytes = LEN_NONE;
    end
  end

endmodule

@@ hdl/mixed_length_instruction_decoder_top.sv @@
`timescale 1ns / 1ps
// Mixed 16/32-bit instruction decoder.
// req carries two halfwords, the byte count present in the fetch buffer and
// the pc; rsp carries one decoded item per request: length used, mnemonic
// code, condition, test condition, suffix, operand layout, three register
// numbers and the immediate or absolute branch/jump target.
// Both channels use valid/ready; an item moves on an edge with both high.
// An accepted item passes through an input register, one pass of decode logic
// plus the target adder, then the result register, where rsp.valid rises.
// Throughput is one item per cycle while rsp.ready stays high; the input register
// can still take an item while a finished result waits in the result register,
// and only when both are full and rsp.ready is low does req.ready fall.
// A stalled result holds steady until taken. Items carry no state between
// them. Synchronous reset empties both registers; no item is lost or repeated
// across a stall.
module mixed_length_instruction_decoder_top import mlid_pkg::*; (
  input logic        clk,
  input logic        rst,
  mlid_req_if.sink   req,
  mlid_rsp_if.source rsp
);

  logic        s1_valid;
  logic [15:0] s1_first_half;
  logic [15:0] s1_second_half;
  logic [2:0]  s1_bytes_available;
  logic [31:0] s1_pc;
  logic        out_valid;
  dec_t        out_dec;
  dec_t        dec;
  logic        out_open;

  // handshake
  assign out_open  = !out_valid || rsp.ready;
  assign req.ready = !s1_valid || out_open;

  // valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (req.ready) begin
        s1_valid <= req.valid;
      end
      if (out_open) begin
        out_valid <= s1_valid;
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_first_half      <= req.first_half;
      s1_second_half     <= req.second_half;
      s1_bytes_available <= req.bytes_available;
      s1_pc              <= req.pc;
    end
  end

  mlid_decode u_decode (
    .first_half      (s1_first_half),
    .second_half     (s1_second_half),
    .bytes_available (s1_bytes_available),
    .pc              (s1_pc),
    .dec             (dec)
  );

  // result register
  always_ff @(posedge clk) begin
    if (s1_valid && out_open) begin
      out_dec <= dec;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.consumed_bytes = out_dec.consumed_bytes;
  assign rsp.mnemonic       = out_dec.mnemonic;
  assign rsp.condition      = out_dec.condition;
  assign rsp.test_condition = out_dec.test_condition;
  assign rsp.suffix         = out_dec.suffix;
  assign rsp.operand_form   = out_dec.operand_form;
  assign rsp.reg_first      = out_dec.reg_first;
  assign rsp.reg_second     = out_dec.reg_second;
  assign rsp.reg_third      = out_dec.reg_third;
  assign rsp.immediate      = out_dec.immediate;

  // checks
  a_short_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_dec.consumed_bytes == LEN_NONE |->
      out_dec.mnemonic == MN_INVALID && out_dec.immediate == 32'h0 &&
      out_dec.operand_form == F_NONE)
    else $error("too-short item carries decoded fields");

  a_invalid_defaults: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_dec.consumed_bytes != LEN_NONE && out_dec.mnemonic == MN_INVALID |->
      out_dec.condition == COND_ALWAYS && out_dec.test_condition == TC_NONE &&
      out_dec.suffix == S_NONE)
    else $error("invalid encoding with non-default fields");

  a_stage_held: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_open |=> s1_valid && $stable(s1_pc))
    else $error("input register lost an item while blocked");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && !s1_valid)
    else $error("registers not empty after reset");

endmodule

@@ sim/mlid_checker.sv @@
`timescale 1ns / 1ps
module mlid_checker import mlid_pkg::*; (
  input  logic clk,
  input  logic rst,
  mlid_req_if  req,
  mlid_rsp_if  rsp,
  output int   fail_count,
  output int   pending
);

  dec_t decoded_q[$];

  assign pending = decoded_q.size();

  function automatic logic [31:0] sx(input logic [31:0] x, input int b);
    logic [31:0] m;
    m = 32'd1 << (b - 1);
    x = x & ((32'd1 << b) - 1);
    return (x ^ m) - m;
  endfunction

  function automatic dec_t fill(input dec_t d, input logic [6:0] mn, input logic [4:0] f,
                                input logic [4:0] r1, input logic [4:0] r2,
                                input logic [4:0] r3, input logic [31:0] imm);
    dec_t o;
    o = d;
    o.mnemonic = mn;
    o.operand_form = f;
    o.reg_first = r1;
    o.reg_second = r2;
    o.reg_third = r3;
    o.immediate = imm;
    return o;
  endfunction

  function automatic logic [6:0] ldst_code(input logic [2:0] s);
    logic [6:0] t [8];
    t = '{MN_LW, MN_LH, MN_LHU, MN_LB, MN_SW, MN_SH, MN_LBU, MN_SB};
    return t[s];
  endfunction

  function automatic logic [6:0] short_alu_code(input logic [3:0] s);
    logic [6:0] t [16];
    t = '{MN_ADD, MN_SUB, MN_NEG, MN_CMP, MN_AND, MN_OR, MN_NOT, MN_XOR,
          MN_LW, MN_LH, MN_POP, MN_LBU, MN_SW, MN_SH, MN_PUSH, MN_SB};
    return t[s];
  endfunction

  // special group (major 0) of long instructions
  function automatic dec_t decode_special(input dec_t d, input logic [29:0] w);
    logic [4:0] rd, ra, rb;
    logic [5:0] op;
    logic [2:0] c;
    logic [6:0] mn;
    rd = w[24:20];
    ra = w[19:15];
    rb = w[14:10];
    op = w[6:1];
    c = w[0] ? S_C : S_NONE;
    mn = MN_INVALID;
    case (op)
      6'h00: d = fill(d, MN_NOP, F_NONE, 0, 0, 0, 0);
      6'h01: d = fill(d, MN_SYSCALL, F_D, 0, 0, 0, {17'd0, w[24:10]});
      6'h02: begin d = fill(d, MN_TRAP, F_D, 0, 0, 0, ra); d.condition = rb[3:0]; end
      6'h03: d = fill(d, MN_SDBBP, F_D, 0, 0, 0, ra);
      6'h04: begin
        d = fill(d, MN_BR, F_R, ra, 0, 0, 0);
        d.condition = rb[3:0];
        d.suffix = w[0] ? S_L : S_NONE;
      end
      6'h05: d = fill(d, MN_PFLUSH, F_NONE, 0, 0, 0, 0);
      6'h06: d = fill(d, MN_ALW, F_RM, rd, ra, 0, 0);
      6'h07: d = fill(d, MN_ASW, F_RM, rd, ra, 0, 0);
      6'h0C, 6'h0D: begin
        d = fill(d, op == 6'h0C ? MN_CMP : MN_CMPZ, F_RR, ra, rb, 0, 0);
        d.test_condition = rd[1:0];
        d.suffix = c;
      end
      6'h0F: begin d = fill(d, MN_NEG, F_RR, rd, ra, 0, 0); d.suffix = c; end
      6'h14: begin d = fill(d, MN_BITCLR, F_RRD, rd, ra, 0, rb); d.suffix = c; end
      6'h15: begin d = fill(d, MN_BITSET, F_RRD, rd, ra, 0, rb); d.suffix = c; end
      6'h16: begin d = fill(d, MN_BITTST, F_RD, ra, 0, 0, rb); d.suffix = c; end
      6'h17: begin d = fill(d, MN_BITTGL, F_RRD, rd, ra, 0, rb); d.suffix = c; end
      6'h20: begin
        d = fill(d, MN_MUL, F_RR, ra, rb, 0, 0);
        d.suffix = w[0] ? S_F : S_NONE;
      end
      6'h21: d = fill(d, MN_MULU, F_RR, ra, rb, 0, 0);
      6'h22: d = fill(d, MN_DIV, F_RR, ra, rb, 0, 0);
      6'h23: d = fill(d, MN_DIVU, F_RR, ra, rb, 0, 0);
      6'h24, 6'h25: begin
        mn = (op == 6'h24) ? MN_MFCEL : MN_MTCEL;
        if (rb == 1 || rb == 2) d = fill(d, mn + rb - 1, F_R, rd, 0, 0, 0);
        else if (rb == 3) d = fill(d, mn + 2, F_RR, rd, ra, 0, 0);
      end
      6'h28: d = fill(d, MN_MFSR, F_RSR, ra, rb, 0, 0);
      6'h29: d = fill(d, MN_MTSR, F_RSR, ra, rb, 0, 0);
      6'h2A: begin d = fill(d, MN_T, F_NONE, 0, 0, 0, 0); d.condition = rb[3:0]; end
      6'h2B: begin d = fill(d, MN_MV, F_RR, rd, ra, 0, 0); d.condition = rb[3:0]; end
      6'h2C, 6'h2D, 6'h2E, 6'h2F: begin
        d = fill(d, MN_EXTSB + (op - 6'h2C), F_RR, rd, ra, 0, 0);
        d.suffix = c;
      end
      6'h30: d = fill(d, MN_LCB, F_MP, 0, ra, 0, 0);
      6'h31: d = fill(d, MN_LCW, F_RMP, rd, ra, 0, 0);
      6'h33: d = fill(d, MN_LCE, F_RMP, rd, ra, 0, 0);
      6'h34: d = fill(d, MN_SCB, F_RMP, rd, ra, 0, 0);
      6'h35: d = fill(d, MN_SCW, F_RMP, rd, ra, 0, 0);
      6'h37: d = fill(d, MN_SCE, F_MP, 0, ra, 0, 0);
      6'h38: begin d = fill(d, MN_SLLI, F_RRD, rd, ra, 0, rb); d.suffix = c; end
      6'h3A, 6'h3B, 6'h3C, 6'h3D, 6'h3E, 6'h3F: begin
        d = fill(d, MN_SRLI + (op - 6'h3A), F_RRD, rd, ra, 0, rb);
        d.suffix = c;
      end
      default: begin
        // three-register alu ops
        case (op)
          6'h08: mn = MN_ADD;
          6'h09: mn = MN_ADDC;
          6'h0A: mn = MN_SUB;
          6'h10: mn = MN_AND;
          6'h11: mn = MN_OR;
          6'h12: mn = MN_NOT;
          6'h13: mn = MN_XOR;
          6'h18: mn = MN_SLL;
          6'h1A: mn = MN_SRL;
          6'h1B: mn = MN_SRA;
          6'h1C: mn = MN_ROR;
          6'h1D: mn = MN_RORC;
          6'h1E: mn = MN_ROL;
          6'h1F: mn = MN_ROLC;
          default: mn = MN_INVALID;
        endcase
        if (mn != MN_INVALID) begin
          d = fill(d, mn, F_RRR, rd, ra, rb, 0);
          d.suffix = c;
        end
      end
    endcase
    return d;
  endfunction

  // 16-bit immediate groups
  function automatic dec_t decode_imm(input dec_t d, input logic [29:0] w,
                                      input logic [6:0] base);
    logic [31:0] im;
    logic [4:0] rd;
    logic ok;
    im = {16'd0, w[16:1]};
    rd = w[24:20];
    ok = 1'b1;
    case (w[19:17])
      3'd0: d = fill(d, base, F_RD, rd, 0, 0, sx(im, 16));
      3'd2: d = fill(d, base + 1, F_RD, rd, 0, 0, sx(im, 16));
      3'd4: d = fill(d, base + 2, F_RH, rd, 0, 0, im);
      3'd5: d = fill(d, base + 3, F_RH, rd, 0, 0, im);
      3'd6: d = fill(d, base + 4, base == MN_ADDI ? F_RD : F_RH, rd, 0, 0, im);
      default: ok = 1'b0;
    endcase
    if (ok) d.suffix = w[0] ? S_C : S_NONE;
    return d;
  endfunction

  function automatic dec_t decode_long(input dec_t d, input logic [29:0] w,
                                       input logic [31:0] pc);
    logic [4:0] major, rd, ra;
    logic [31:0] disp;
    major = w[29:25];
    rd = w[24:20];
    ra = w[19:15];
    case (major)
      5'h00: d = decode_special(d, w);
      5'h01: d = decode_imm(d, w, MN_ADDI);
      5'h05: d = decode_imm(d, w, MN_ADDIS);
      5'h02: begin
        d = fill(d, MN_J, F_W, 0, 0, 0, (pc & JUMP32_REGION) | {7'd0, w[24:1], 1'b0});
        d.suffix = w[0] ? S_L : S_NONE;
      end
      5'h03, 5'h07:
        d = fill(d, ldst_code(w[2:0]), major == 5'h03 ? F_RMDP : F_RMPD, rd, ra, 0,
                 sx({20'd0, w[14:3]}, 12));
      5'h04: begin
        disp = sx({12'd0, w[24:15], w[9:1], 1'b0}, 20);
        d = fill(d, MN_B, F_W, 0, 0, 0, pc + disp);
        d.condition = w[13:10];
        d.suffix = w[0] ? S_L : S_NONE;
      end
      5'h08, 5'h0C, 5'h0D: begin
        d = fill(d, major == 5'h08 ? MN_ADDRI : (major == 5'h0C ? MN_ANDRI : MN_ORRI),
                 F_RRH, ra, rd, 0, sx({18'd0, w[14:1]}, 14));
        d.suffix = w[0] ? S_C : S_NONE;
      end
      5'h10, 5'h11, 5'h12, 5'h13, 5'h14, 5'h15, 5'h16, 5'h17:
        d = fill(d, ldst_code(major[2:0]), F_RMD, rd, ra, 0, sx({17'd0, w[14:0]}, 15));
      default: ;
    endcase
    return d;
  endfunction

  function automatic dec_t decode_short(input dec_t d, input logic [15:0] h,
                                        input logic [31:0] pc);
    logic [4:0] rd, ra;
    logic [3:0] lo;
    logic [31:0] i5;
    logic bang;
    rd = {1'b0, h[11:8]};
    ra = {1'b0, h[7:4]};
    lo = h[3:0];
    i5 = {27'd0, h[7:3]};
    bang = 1'b1;
    case (h[14:12])
      3'd0: begin
        case (lo)
          4'h0: d = fill(d, MN_NOP, F_NONE, 0, 0, 0, 0);
          4'h1: d = fill(d, MN_MLFH, F_RR, rd, ra + 16, 0, 0);
          4'h2: d = fill(d, MN_MHFL, F_RR, rd + 16, ra, 0, 0);
          4'h3: d = fill(d, MN_MV, F_RR, rd, ra, 0, 0);
          4'h4, 4'hC: begin
            d = fill(d, MN_BR, F_R, ra, 0, 0, 0);
            d.condition = rd[3:0];
            d.suffix = (lo == 4'hC) ? S_LBANG : S_BANG;
            bang = 1'b0;
          end
          4'h5: begin d = fill(d, MN_T, F_R, ra, 0, 0, 0); d.condition = rd[3:0]; end
          default: bang = 1'b0;
        endcase
      end
      3'd1: begin
        if (lo > 1 || rd > 1) bang = 1'b0;
        else d = fill(d, (lo == 0 ? MN_MTCEL : MN_MFCEL) + rd, F_R, ra, 0, 0, 0);
      end
      3'd2: begin
        if (lo < 8) d = fill(d, short_alu_code(lo), F_RR, rd, ra, 0, 0);
        else if (lo == 4'hA || lo == 4'hE)
          d = fill(d, short_alu_code(lo), F_RM, rd + {h[7], 4'd0}, {2'd0, h[6:4]}, 0, 0);
        else d = fill(d, short_alu_code(lo), F_RM, rd, ra, 0, 0);
      end
      3'd3: begin
        d = fill(d, MN_J, F_W, 0, 0, 0, (pc & JUMP16_REGION) | {20'd0, h[11:1], 1'b0});
        d.suffix = h[0] ? S_LBANG : S_BANG;
        bang = 1'b0;
      end
      3'd4: begin
        d = fill(d, MN_B, F_W, 0, 0, 0, pc + (sx({24'd0, h[7:0]}, 8) << 1));
        d.condition = rd[3:0];
      end
      3'd5: d = fill(d, MN_LDIU, F_RD, rd, 0, 0, {24'd0, h[7:0]});
      3'd6: begin
        case (h[2:0])
          3'd0: d = fill(d, MN_ADDEI, F_RD, rd, 0, 0, sx(i5, 5));
          3'd1: d = fill(d, MN_SLLI, F_RD, rd, 0, 0, i5);
          3'd2: d = fill(d, MN_SDBBP, F_D, 0, 0, 0, i5);
          3'd3: d = fill(d, MN_SRLI, F_RD, rd, 0, 0, i5);
          3'd4: d = fill(d, MN_BITCLR, F_RD, rd, 0, 0, i5);
          3'd5: d = fill(d, MN_BITSET, F_RD, rd, 0, 0, i5);
          3'd6: d = fill(d, MN_BITTST, F_RD, rd, 0, 0, i5);
          default: bang = 1'b0;
        endcase
      end
      default: begin
        case (h[2:0])
          3'd0: d = fill(d, MN_LWP, F_RD, rd, 0, 0, i5 << 2);
          3'd1: d = fill(d, MN_LHP, F_RD, rd, 0, 0, i5 << 1);
          3'd3: d = fill(d, MN_LBUP, F_RD, rd, 0, 0, i5);
          3'd4: d = fill(d, MN_SWP, F_RD, rd, 0, 0, i5 << 2);
          3'd5: d = fill(d, MN_SHP, F_RD, rd, 0, 0, i5 << 1);
          3'd6: d = fill(d, MN_SBP, F_RD, rd, 0, 0, i5);
          default: bang = 1'b0;
        endcase
      end
    endcase
    if (bang) d.suffix = S_BANG;
    return d;
  endfunction

  function automatic dec_t decode_item(input logic [15:0] a, input logic [15:0] b,
                                       input logic [2:0] n_in, input logic [31:0] pc);
    dec_t d;
    logic [2:0] n;
    logic [31:0] w;
    d = '0;
    n = (n_in > 4) ? 3'd4 : n_in;
    if (n >= 2 && (!a[15] || n >= 4)) begin
      d.condition = COND_ALWAYS;
      d.test_condition = TC_NONE;
      if (a[15]) begin
        w = (({16'd0, a} & LOW_HALF_MASK) | ({16'd0, b} << 15)) & WORD30_MASK;
        d = decode_long(d, w[29:0], pc);
        d.consumed_bytes = LEN_LONG;
      end else begin
        d = decode_short(d, a, pc);
        d.consumed_bytes = LEN_SHORT;
      end
    end
    return d;
  endfunction

  // predict on request, compare on result
  always @(posedge clk) begin
    dec_t got, want;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (req.valid && req.ready)
        decoded_q.push_back(decode_item(req.first_half, req.second_half,
                                        req.bytes_available, req.pc));
      if (rsp.valid && rsp.ready) begin
        got = {rsp.consumed_bytes, rsp.mnemonic, rsp.condition, rsp.test_condition,
               rsp.suffix, rsp.operand_form, rsp.reg_first, rsp.reg_second,
               rsp.reg_third, rsp.immediate};
        if (decoded_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected item: %h", got);
        end else begin
          want = decoded_q.pop_front();
          if (got !== want) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch: len %0d/%0d mn %0d/%0d cond %0d/%0d tc %0d/%0d suf %0d/%0d form %0d/%0d regs %0d,%0d,%0d/%0d,%0d,%0d imm %h/%h",
                       want.consumed_bytes, got.consumed_bytes, want.mnemonic, got.mnemonic,
                       want.condition, got.condition, want.test_condition,
                       got.test_condition, want.suffix, got.suffix, want.operand_form,
                       got.operand_form, want.reg_first, want.reg_second, want.reg_third,
                       got.reg_first, got.reg_second, got.reg_third, want.immediate,
                       got.immediate);
          end
        end
      end
    end
  end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
module tb import mlid_pkg::*;;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int fail_count, pending;
  int send_idle = 0, recv_stall = 0;
  int cycles = 0;
  logic timed_out = 1'b0;

  mlid_req_if req ();
  mlid_rsp_if rsp ();

  mixed_length_instruction_decoder_top dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));
  mlid_checker chk (.clk(clk), .rst(rst), .req(req), .rsp(rsp),
                    .fail_count(fail_count), .pending(pending));

  always #6 clk = ~clk;

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver stalls
  always @(negedge clk) rsp.ready <= ($urandom_range(99) >= recv_stall);

  // present one item and hold it until taken
  task automatic send_item(input logic [15:0] a, input logic [15:0] b,
                           input logic [2:0] n, input logic [31:0] pc);
    while ($urandom_range(99) < send_idle) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid <= 1'b1;
    req.first_half <= a;
    req.second_half <= b;
    req.bytes_available <= n;
    req.pc <= pc;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // mostly full-length random instructions, some short buffers
  task automatic random_item();
    logic [15:0] a;
    logic [15:0] b;
    logic [2:0] n;
    a = $urandom;
    b = $urandom;
    n = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : (a[15] ? 3'd4 : 3'd2);
    if ($urandom_range(3) == 0) n = 3'($urandom_range(4, 7));
    // favor the special group of long instructions (major field is b[14:10])
    if (a[15] && $urandom_range(3) == 0) b[14:10] = 5'd0;
    send_item(a, b, n, $urandom);
  endtask

  initial begin
    int p;
    req.valid = 1'b0;
    req.first_half = '0;
    req.second_half = '0;
    req.bytes_available = '0;
    req.pc = '0;
    rsp.ready = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: short buffers, extremes, branches, cmp test field
    send_item(16'h0000, 16'h0000, 3'd0, 32'h0);
    send_item(16'h0000, 16'h0000, 3'd1, 32'h0);
    send_item(16'h8000, 16'hFFFF, 3'd3, 32'h0);
    send_item(16'hFFFF, 16'hFFFF, 3'd7, 32'hFFFF_FFFF);
    send_item(16'h7FFF, 16'h0000, 3'd5, 32'hFFFF_FFFF);
    send_item(16'h4080, 16'h0000, 3'd2, 32'h0000_0000);
    send_item(16'h407F, 16'h0000, 3'd2, 32'hFFFF_FFFE);
    send_item(16'h3FFF, 16'h0000, 3'd2, 32'hFFFF_FFFF);
    send_item(16'h0F0C, 16'h0000, 3'd2, 32'h0);
    send_item(16'h2F8A, 16'h0000, 3'd2, 32'h0);
    send_item(16'h8018, 16'h03F0, 3'd4, 32'h0);
    send_item(16'h801A, 16'h03F0, 3'd4, 32'h0);
    send_item(16'hFC08, 16'h0400, 3'd4, 32'h0);
    send_item(16'h8061, 16'h0000, 3'd4, 32'h0);
    send_item(16'hFFFF, 16'h1001, 3'd4, 32'hFFFF_FFFF);
    send_item(16'hFFFF, 16'h0901, 3'd4, 32'h8000_0000);
    send_item(16'h8001, 16'h0C00, 3'd4, 32'h0);
    send_item(16'hFFFE, 16'h7FFF, 3'd4, 32'hFFFF_FFFF);
    send_item(16'h8000, 16'h8000, 3'd6, 32'h1234_5678);
    send_item(16'h6007, 16'h0000, 3'd2, 32'h0);
    send_item(16'h7002, 16'h0000, 3'd2, 32'h0);

    // random phases: none, sender idle, receiver stall, both
    for (p = 0; p < 4; p++) begin
      send_idle = (p == 1) ? 85 : ((p == 3) ? 6 : 0);
      recv_stall = (p == 2) ? 85 : ((p == 3) ? 6 : 0);
      repeat (333) random_item();
    end
    req.valid <= 1'b0;
    recv_stall = 0;

    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/mlid_pkg.sv
hdl/mlid_req_if.sv
hdl/mlid_rsp_if.sv
hdl/mlid_decode.sv
hdl/mixed_length_instruction_decoder_top.sv
sim/mlid_checker.sv
sim/tb.sv
